[rtl/chll_pkg.sv]
// ----------------------------------------------------------------------------
// chll_pkg
// Shared types and constants for the column statistics / distinct count core.
// ----------------------------------------------------------------------------
package chll_pkg;

    localparam int unsigned INDEX_BITS = 6;
    localparam int unsigned REG_COUNT  = 1 << INDEX_BITS;
    localparam int unsigned RANK_TOP   = 65 - INDEX_BITS;

    localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_LOW    = 9'h1B3;   // prime is 2^40 + 0x1B3
    localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_INIT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_INIT   = 64'h8000_0000_0000_0000;

    localparam int unsigned SUM_W = 66;
    localparam int unsigned DEN_W = 75;
    localparam int unsigned LIM_W = 83;
    localparam int unsigned QUO_W = 82;

    // 0.709 * 1000 scaled numerators: 709 * 2^71 for the limit, 709 * 2^72 for the divider
    localparam logic [LIM_W-1:0] LIN_LIMIT = LIM_W'(709) << 71;
    localparam logic [QUO_W-1:0] DIV_NUM   = QUO_W'(709) << 72;

    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       lzc_init;
        logic       lzc_step;
        logic       rd_en;
        logic       rd_sel_slot;
        logic [5:0] rd_addr;
        logic       upd_wr;
        logic       sum_clr;
        logic       sum_step;
        logic       sum_acc;
        logic       mul_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } chll_cmd_t;

    typedef struct packed {
        logic lzc_done;
        logic small_range;
        logic out_free;
    } chll_sts_t;

    // round(64 * ln(64 / z)) at position z-1
    function automatic logic [8:0] lin_count(input logic [5:0] idx);
        logic [8:0] r;
        case (idx)
            6'd0: r = 9'd266;  6'd1: r = 9'd222;  6'd2: r = 9'd196;  6'd3: r = 9'd177;
            6'd4: r = 9'd163;  6'd5: r = 9'd151;  6'd6: r = 9'd142;  6'd7: r = 9'd133;
            6'd8: r = 9'd126;  6'd9: r = 9'd119;  6'd10: r = 9'd113; 6'd11: r = 9'd107;
            6'd12: r = 9'd102; 6'd13: r = 9'd97;  6'd14: r = 9'd93;  6'd15: r = 9'd89;
            6'd16: r = 9'd85;  6'd17: r = 9'd81;  6'd18: r = 9'd78;  6'd19: r = 9'd74;
            6'd20: r = 9'd71;  6'd21: r = 9'd68;  6'd22: r = 9'd65;  6'd23: r = 9'd63;
            6'd24: r = 9'd60;  6'd25: r = 9'd58;  6'd26: r = 9'd55;  6'd27: r = 9'd53;
            6'd28: r = 9'd51;  6'd29: r = 9'd48;  6'd30: r = 9'd46;  6'd31: r = 9'd44;
            6'd32: r = 9'd42;  6'd33: r = 9'd40;  6'd34: r = 9'd39;  6'd35: r = 9'd37;
            6'd36: r = 9'd35;  6'd37: r = 9'd33;  6'd38: r = 9'd32;  6'd39: r = 9'd30;
            6'd40: r = 9'd28;  6'd41: r = 9'd27;  6'd42: r = 9'd25;  6'd43: r = 9'd24;
            6'd44: r = 9'd23;  6'd45: r = 9'd21;  6'd46: r = 9'd20;  6'd47: r = 9'd18;
            6'd48: r = 9'd17;  6'd49: r = 9'd16;  6'd50: r = 9'd15;  6'd51: r = 9'd13;
            6'd52: r = 9'd12;  6'd53: r = 9'd11;  6'd54: r = 9'd10;  6'd55: r = 9'd9;
            6'd56: r = 9'd7;   6'd57: r = 9'd6;   6'd58: r = 9'd5;   6'd59: r = 9'd4;
            6'd60: r = 9'd3;   6'd61: r = 9'd2;   6'd62: r = 9'd1;   6'd63: r = 9'd0;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/column_stats_hll_update_core.sv]
// sequence: a byte-wise hash of the input value, a rank search, a pass over the 64 rank
// registers and a restoring divider (skipped in the small range) run in turn for each item
// throughput: one item at a time; a new item is taken while the last result waits
// reset: aresetn synchronous active low, clears stats, rank valid bits and handshakes
// ----------------------------------------------------------------------------
// column_stats_hll_update_core
// Column min/max/row count with a 64-register distinct count sketch.
// ----------------------------------------------------------------------------
module column_stats_hll_update_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [63:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_min_value,
    output logic signed [63:0] m_max_value,
    output logic [47:0]        m_rows_seen,
    output logic [47:0]        m_distinct_estimate
);
    import chll_pkg::*;

    chll_cmd_t cmd;
    chll_sts_t sts;

    chll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chll_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_value             (s_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_min_value         (m_min_value),
        .m_max_value         (m_max_value),
        .m_rows_seen         (m_rows_seen),
        .m_distinct_estimate (m_distinct_estimate)
    );

endmodule

[rtl/chll_ctrl.sv]
// ----------------------------------------------------------------------------
// chll_ctrl
// Sequencer: hash, rank search, register update, sum, divide (skipped in the small range), deliver.
// ----------------------------------------------------------------------------
module chll_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chll_pkg::chll_sts_t sts,
    output chll_pkg::chll_cmd_t cmd
);
    import chll_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_HASH = 4'd1;
    localparam logic [3:0] ST_LZI  = 4'd2;
    localparam logic [3:0] ST_LZC  = 4'd3;
    localparam logic [3:0] ST_UPD  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                cnt_next      = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7) begin
                    state_next = ST_LZI;
                end
            end
            ST_LZI: begin
                cmd.lzc_init = 1'b1;
                state_next   = ST_LZC;
            end
            ST_LZC: begin
                cmd.lzc_step    = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_sel_slot = 1'b1;
                if (sts.lzc_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.upd_wr  = 1'b1;
                cmd.sum_clr = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                // read address leads the accumulator by the registered read data
                cmd.rd_en    = ~cnt_reg[6];
                cmd.rd_addr  = cnt_reg[5:0];
                cmd.sum_step = 1'b1;
                cmd.sum_acc  = (cnt_reg != 7'd0);
                cnt_next     = cnt_reg + 7'd1;
                if (cnt_reg[6]) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = sts.small_range ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 7'd1;
                if (cnt_reg == 7'(QUO_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/chll_dp.sv]
// ----------------------------------------------------------------------------
// chll_dp
// Datapath: running stats, FNV-1a hash, rank memory, harmonic sum, divider
// and the output register.
// ----------------------------------------------------------------------------
module chll_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  chll_pkg::chll_cmd_t cmd,
    output chll_pkg::chll_sts_t sts,
    input  logic signed [63:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_min_value,
    output logic signed [63:0]  m_max_value,
    output logic [47:0]         m_rows_seen,
    output logic [47:0]         m_distinct_estimate
);
    import chll_pkg::*;

    function automatic logic [5:0] lz8(input logic [7:0] b);
        logic [5:0] n;
        logic       hit;
        n   = 6'd8;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i] && !hit) begin
                n   = 6'(7 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    logic signed [63:0] min_reg, max_reg;
    logic [47:0]        rows_reg;
    logic [63:0]        val_reg;
    logic [63:0]        hash_reg;
    logic [63:0]        w_reg;
    logic [5:0]         rank_reg;
    logic [5:0]         slot_reg;

    logic [5:0]         rank_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rank_vld_reg;
    logic [5:0]         rd_data_reg;
    logic [5:0]         rd_addr;

    logic [SUM_W-1:0]   sum_reg;
    logic [6:0]         zeros_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W:0]     rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [QUO_W-1:0]   num_reg;
    logic               small_reg;

    logic               m_valid_reg;
    logic signed [63:0] m_min_reg, m_max_reg;
    logic [47:0]        m_rows_reg, m_est_reg;

    // hash step: (h ^ byte) * (2^40 + 0x1B3) mod 2^64
    logic [63:0] hx;
    logic [63:0] hash_next;
    assign hx        = hash_reg ^ {56'd0, val_reg[7:0]};
    assign hash_next = (hx << 40) + 64'(hx * {55'd0, FNV_LOW});

    // harmonic term 2^(59 - r), r clamped
    logic [5:0]       r_cl;
    logic [SUM_W-1:0] term;
    assign r_cl = (rd_data_reg > 6'(RANK_TOP)) ? 6'(RANK_TOP) : rd_data_reg;
    assign term = SUM_W'(1) << (6'(RANK_TOP) - r_cl);

    logic [LIM_W-1:0] lim;
    assign lim = (LIM_W'(den_reg) << 7) + (LIM_W'(den_reg) << 5);

    logic [DEN_W:0] rem_sh;
    logic           rem_ge;
    assign rem_sh = {rem_reg[DEN_W-1:0], num_reg[QUO_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    logic [QUO_W:0]   q_inc;
    logic [QUO_W-1:0] q_half;
    logic [47:0]      est;
    assign q_inc  = {1'b0, quo_reg} + (QUO_W+1)'(1);
    assign q_half = q_inc[QUO_W:1];
    always_comb begin
        if (small_reg) begin
            est = 48'(lin_count(6'(zeros_reg - 7'd1)));
        end else if (|q_half[QUO_W-1:48]) begin
            est = MAX48;
        end else begin
            est = q_half[47:0];
        end
    end

    assign rd_addr = cmd.rd_sel_slot ? slot_reg : cmd.rd_addr;

    assign sts.lzc_done    = (w_reg[63:56] != 8'd0);
    assign sts.small_range = (zeros_reg != 7'd0) && (lim >= LIN_LIMIT);
    assign sts.out_free    = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= MIN_INIT;
            max_reg      <= MAX_INIT;
            rows_reg     <= '0;
            rank_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (s_value < min_reg) min_reg <= s_value;
                if (s_value > max_reg) max_reg <= s_value;
                if (rows_reg != MAX48) rows_reg <= rows_reg + 48'd1;
            end
            if (cmd.upd_wr && (rank_reg > rd_data_reg)) begin
                rank_vld_reg[slot_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // rank memory
    always_ff @(posedge aclk) begin
        if (cmd.upd_wr && (rank_reg > rd_data_reg)) begin
            rank_mem[slot_reg] <= rank_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= rank_vld_reg[rd_addr] ? rank_mem[rd_addr] : 6'd0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg  <= s_value;
            hash_reg <= FNV_BASIS;
        end
        if (cmd.hash_step) begin
            hash_reg <= hash_next;
            val_reg  <= val_reg >> 8;
        end
        if (cmd.lzc_init) begin
            w_reg    <= {hash_reg[63-INDEX_BITS:0], 1'b1, 5'd0};
            rank_reg <= 6'd1;
            slot_reg <= hash_reg[63:64-INDEX_BITS];
        end
        if (cmd.lzc_step) begin
            if (w_reg[63:56] == 8'd0) begin
                w_reg    <= w_reg << 8;
                rank_reg <= rank_reg + 6'd8;
            end else begin
                rank_reg <= rank_reg + lz8(w_reg[63:56]);
            end
        end
        if (cmd.sum_clr) begin
            sum_reg   <= '0;
            zeros_reg <= '0;
        end
        if (cmd.sum_step && cmd.sum_acc) begin
            sum_reg <= sum_reg + term;
            if (rd_data_reg == 6'd0) zeros_reg <= zeros_reg + 7'd1;
        end
        if (cmd.mul_step) begin
            // s * 1000 = s*1024 - s*16 - s*8
            den_reg <= (DEN_W'(sum_reg) << 10) - (DEN_W'(sum_reg) << 4)
                       - (DEN_W'(sum_reg) << 3);
        end
        if (cmd.div_init) begin
            rem_reg   <= '0;
            quo_reg   <= '0;
            num_reg   <= DIV_NUM;
            small_reg <= sts.small_range;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
            num_reg <= num_reg << 1;
        end
        if (cmd.out_load) begin
            m_min_reg  <= min_reg;
            m_max_reg  <= max_reg;
            m_rows_reg <= rows_reg;
            m_est_reg  <= est;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_min_value         = m_min_reg;
    assign m_max_value         = m_max_reg;
    assign m_rows_seen         = m_rows_reg;
    assign m_distinct_estimate = m_est_reg;

endmodule

[rtl/chll_checker.sv]
// ----------------------------------------------------------------------------
// chll_checker
// Port level checks for the column statistics core.
// ----------------------------------------------------------------------------
module chll_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_min_value,
    input logic signed [63:0] m_max_value,
    input logic [47:0]        m_rows_seen
);

    // busy after taking a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready after transaction accepted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rows_seen)))
        else $error("result dropped or changed while stalled");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_value <= m_max_value) && (m_rows_seen != 48'd0))
        else $error("min above max or empty row count");

    // a taken result is never followed by a valid one with a smaller row count
    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid || (m_rows_seen >= $past(m_rows_seen)))
        else $error("row count went backwards");

endmodule

bind column_stats_hll_update_core chll_checker u_chll_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_min_value (m_min_value),
    .m_max_value (m_max_value),
    .m_rows_seen (m_rows_seen)
);
